/* sv/hzcd_pkg.sv */
`default_nettype none
package hzcd_pkg;

    localparam int WINDOW_LEN    = 4096;
    localparam int MAX_CROSSINGS = 128;
    localparam int MAX_RISING    = 64;

    localparam int SAMPLE_W = 24;
    localparam int HYST_W   = 23;
    localparam int IDX_W    = 12;
    localparam int FRAC_W   = 17;
    localparam int NUM_W    = 7;
    localparam int PNUM_W   = 6;
    localparam int ALL_W    = 8;
    localparam int POS_W    = 7;
    localparam int DIV_CNT_W = 5;

    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    localparam logic [HYST_W-1:0] HYST_RESET = 23'd1311;
    localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'd65536;

    typedef enum logic [1:0] {
        SIDE_MID = 2'd0,
        SIDE_POS = 2'd1,
        SIDE_NEG = 2'd2
    } t_side;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_WAIT = 2'd2
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;
        logic accept;
        logic div_step;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic div_last;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

/* sv/hzcd_ctrl.sv */
`default_nettype none
module hzcd_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_s_valid,
    input  hzcd_pkg::t_status i_status,
    output hzcd_pkg::t_cmd    o_cmd
);
    import hzcd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.ready    = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.ready  = 1'b1;
                o_cmd.accept = i_s_valid;
                if (i_s_valid && i_status.hit) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                // The last quotient bit lands at the end of this cycle.
                if (i_status.div_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/hzcd_datapath.sv */
`default_nettype none
module hzcd_datapath (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  hzcd_pkg::t_cmd                        i_cmd,
    output hzcd_pkg::t_status                     o_status,
    input  wire                                   i_cfg_valid,
    input  wire  [hzcd_pkg::HYST_W-1:0]           i_cfg_data,
    input  wire  signed [hzcd_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire                                   i_start,
    output logic                                  o_m_valid,
    input  wire                                   i_m_ready,
    output logic [hzcd_pkg::OUT_DATA_W-1:0]       o_m_data,
    output logic [hzcd_pkg::OUT_USER_W-1:0]       o_m_user
);
    import hzcd_pkg::*;

    localparam int DVD_W = SAMPLE_W + FRAC_W;

    logic [HYST_W-1:0]          r_hyst;
    logic signed [SAMPLE_W-1:0] r_prev;
    t_side                      r_armed;
    logic [IDX_W-1:0]           r_idx;
    logic [ALL_W-1:0]           r_all;
    logic [POS_W-1:0]           r_pos;

    // Pending event fields, held while the divider runs.
    logic [IDX_W-1:0]  r_p_idx;
    logic              r_p_rising;
    logic [NUM_W-1:0]  r_p_num;
    logic              r_p_rec;
    logic [PNUM_W-1:0] r_p_pnum;

    logic [SAMPLE_W-1:0]  r_rem;
    logic [SAMPLE_W-1:0]  r_den;
    logic [FRAC_W-1:0]    r_low;
    logic [FRAC_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_o_idx;
    logic [FRAC_W-1:0] r_o_frac;
    logic              r_o_rising;
    logic [NUM_W-1:0]  r_o_num;
    logic              r_o_rec;
    logic [PNUM_W-1:0] r_o_pnum;

    logic signed [SAMPLE_W-1:0] w_h;
    logic signed [SAMPLE_W-1:0] w_nh;
    t_side                      w_side;
    t_side                      w_arm;
    logic                       w_up;
    logic                       w_down;
    logic                       w_ignore;
    logic                       w_hit;
    logic                       w_rec;
    logic signed [SAMPLE_W:0]   w_ea;
    logic signed [SAMPLE_W:0]   w_eb;
    logic signed [SAMPLE_W:0]   w_num_x;
    logic signed [SAMPLE_W:0]   w_den_x;
    logic [SAMPLE_W-1:0]        w_num;
    logic [SAMPLE_W-1:0]        w_den;
    logic [DVD_W-1:0]           w_dvd;
    logic [SAMPLE_W:0]          w_trial;
    logic                       w_ge;
    logic [FRAC_W-1:0]          w_frac;
    logic                       w_out_free;

    assign w_h  = $signed({1'b0, r_hyst});
    assign w_nh = -w_h;

    always_comb begin
        if (i_sample >= w_h) begin
            w_side = SIDE_POS;
        end else if (i_sample <= w_nh) begin
            w_side = SIDE_NEG;
        end else begin
            w_side = SIDE_MID;
        end
    end

    // The armed side takes the new sample first, then the crossing check uses it.
    assign w_arm    = (w_side != SIDE_MID) ? w_side : r_armed;
    assign w_up     = (w_arm == SIDE_NEG) && (r_prev <= 0) && (i_sample > 0);
    assign w_down   = (w_arm == SIDE_POS) && (r_prev >= 0) && (i_sample < 0);
    assign w_ignore = (r_idx >= IDX_W'(WINDOW_LEN - 1)) || (r_all >= ALL_W'(MAX_CROSSINGS));
    assign w_hit    = !i_start && !w_ignore && (w_up || w_down);
    assign w_rec    = w_up && (r_pos < POS_W'(MAX_RISING));

    assign w_ea    = {r_prev[SAMPLE_W-1], r_prev};
    assign w_eb    = {i_sample[SAMPLE_W-1], i_sample};
    assign w_num_x = w_up ? -w_ea : w_ea;
    assign w_den_x = w_up ? (w_eb - w_ea) : (w_ea - w_eb);
    assign w_num   = w_num_x[SAMPLE_W-1:0];
    assign w_den   = w_den_x[SAMPLE_W-1:0];
    // Dividend is num * 2^16 plus half the divisor, for round to nearest.
    assign w_dvd   = {1'b0, w_num, {(FRAC_W-1){1'b0}}}
                   + {{(FRAC_W+1){1'b0}}, w_den[SAMPLE_W-1:1]};

    assign w_trial = {r_rem, r_low[FRAC_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_frac  = (r_quo > FRAC_ONE) ? FRAC_ONE : r_quo;

    assign w_out_free = !r_out_valid || i_m_ready;

    assign o_status.hit      = w_hit;
    assign o_status.div_last = (r_cnt == DIV_CNT_W'(FRAC_W - 1));
    assign o_status.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hyst <= HYST_RESET;
        end else if (i_cfg_valid) begin
            r_hyst <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_armed <= SIDE_MID;
            r_idx   <= '0;
            r_all   <= '0;
            r_pos   <= '0;
        end else if (i_cmd.accept) begin
            if (i_start) begin
                r_prev  <= i_sample;
                r_armed <= w_side;
                r_idx   <= '0;
                r_all   <= '0;
                r_pos   <= '0;
            end else if (!w_ignore) begin
                r_prev  <= i_sample;
                r_idx   <= r_idx + 1'b1;
                r_armed <= w_hit ? SIDE_MID : w_arm;
                if (w_hit) begin
                    r_all <= r_all + 1'b1;
                end
                if (w_hit && w_rec) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_hit) begin
            r_p_idx    <= r_idx;
            r_p_rising <= w_up;
            r_p_num    <= r_all[NUM_W-1:0];
            r_p_rec    <= w_rec;
            r_p_pnum   <= w_rec ? r_pos[PNUM_W-1:0] : '0;
            r_rem      <= w_dvd[DVD_W-1:FRAC_W];
            r_low      <= w_dvd[FRAC_W-1:0];
            r_den      <= w_den;
            r_quo      <= '0;
            r_cnt      <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? SAMPLE_W'(w_trial - {1'b0, r_den}) : w_trial[SAMPLE_W-1:0];
            r_low <= {r_low[FRAC_W-2:0], 1'b0};
            r_quo <= {r_quo[FRAC_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_idx    <= r_p_idx;
            r_o_frac   <= w_frac;
            r_o_rising <= r_p_rising;
            r_o_num    <= r_p_num;
            r_o_rec    <= r_p_rec;
            r_o_pnum   <= r_p_pnum;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = {{(OUT_DATA_W - IDX_W - FRAC_W - NUM_W - PNUM_W){1'b0}},
                        r_o_pnum, r_o_num, r_o_frac, r_o_idx};
    assign o_m_user  = {r_o_rec, r_o_rising};

endmodule
`default_nettype wire

/* sv/hysteresis_zero_cross_detector_top.sv */
// An item that causes no crossing is taken while ready is high and gives no result.
// A crossing item gets its interpolated fraction from the 17-step radix-2 divider;
// its result waits for a free output register; ready is low meanwhile.
// One sample per cycle between crossings; none until a crossing result is loaded.
// Reset: synchronous, active low; clears the window state and loads hysteresis 1311.
`default_nettype none
module hysteresis_zero_cross_detector_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [hzcd_pkg::HYST_W-1:0]        i_cfg_data,     // hysteresis
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire  [hzcd_pkg::SAMPLE_W-1:0]      i_s_axis_tdata, // sample
    input  wire                                i_s_axis_tuser, // window_start
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // crossing_index, crossing_fraction, crossing_number, positive_number, zero pad
    output logic [hzcd_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // rising, positive_recorded
    output logic [hzcd_pkg::OUT_USER_W-1:0]    o_m_axis_tuser
);
    import hzcd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = w_cmd.ready;

    hzcd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    hzcd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_sample    ($signed(i_s_axis_tdata)),
        .i_start     (i_s_axis_tuser),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_m_data    (o_m_axis_tdata),
        .o_m_user    (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

/* sv/hzcd_checker.sv */
`default_nettype none
module hzcd_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_m_axis_tvalid,
    input wire                              i_m_axis_tready,
    input wire [hzcd_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input wire [hzcd_pkg::OUT_USER_W-1:0]   o_m_axis_tuser
);
    import hzcd_pkg::*;

    // A stalled result item keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result item changed while stalled");

    // The interpolated fraction never exceeds one.
    a_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[IDX_W+FRAC_W-1:IDX_W] <= FRAC_ONE))
        else $error("crossing fraction above one");

    // Only rising crossings enter the rising list.
    a_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> o_m_axis_tuser[0])
        else $error("falling crossing marked as recorded");

    // Unrecorded crossings carry a rising ordinal of zero.
    a_pnum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[1]) |->
            (o_m_axis_tdata[IDX_W+FRAC_W+NUM_W+PNUM_W-1:IDX_W+FRAC_W+NUM_W] == '0))
        else $error("rising ordinal set on unrecorded crossing");

endmodule

bind hysteresis_zero_cross_detector_top hzcd_checker u_hzcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire

/* test/testbench.sv */
`default_nettype none
module testbench;
    import hzcd_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int SAMPLE_MAX    = 8388607;
    localparam int LONG_RUN_LEN  = 300;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [FRAC_W-1:0] frac;
        logic              rising;
        logic [NUM_W-1:0]  number;
        logic              recorded;
        logic [PNUM_W-1:0] pos_number;
    } t_crossing;

    typedef struct {
        logic [SAMPLE_W-1:0] smp;
        logic                start;
    } t_sample_item;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [HYST_W-1:0]     i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [SAMPLE_W-1:0]   i_s_axis_tdata;
    logic                  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;

    hysteresis_zero_cross_detector_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    t_sample_item sample_queue[$];
    t_crossing    pending_crossings[$];

    // Detector state as the testbench tracks it.
    int unsigned hyst_level;
    int          last_sample;
    t_side       armed;
    int          window_idx;
    int          crossing_cnt;
    int          rising_cnt;

    bit in_taken, out_taken, cfg_taken;
    int idle_pct;
    bit hold_req;
    int hold_left;
    int quiet_cycles;
    int mismatches;
    t_crossing got_ev, new_ev, want_ev;

    function automatic t_side side_for(int x);
        int h;
        h = int'(hyst_level);
        if (x >= h) return SIDE_POS;
        if (x <= -h) return SIDE_NEG;
        return SIDE_MID;
    endfunction

    function automatic bit detect_crossing(input int b, input logic start, output t_crossing ev);
        int                a;
        t_side             r;
        bit                up, down;
        longint unsigned   num, den, q;
        ev = '0;
        if (start) begin
            last_sample  = b;
            armed        = side_for(b);
            window_idx   = 0;
            crossing_cnt = 0;
            rising_cnt   = 0;
            return 1'b0;
        end
        // A full window or one that hit the crossing limit ignores samples.
        if (window_idx >= WINDOW_LEN - 1 || crossing_cnt >= MAX_CROSSINGS) return 1'b0;
        a = last_sample;
        r = side_for(b);
        if (r != SIDE_MID) armed = r;
        up   = (armed == SIDE_NEG) && a <= 0 && b > 0;
        down = (armed == SIDE_POS) && a >= 0 && b < 0;
        if (up || down) begin
            num = up ? longint'(-a) : longint'(a);
            den = up ? longint'(b - a) : longint'(a - b);
            q = ((num << 16) + den / 2) / den;
            if (q > 65536) q = 65536;
            ev.index  = window_idx[IDX_W-1:0];
            ev.frac   = q[FRAC_W-1:0];
            ev.rising = up;
            ev.number = crossing_cnt[NUM_W-1:0];
            if (up && rising_cnt < MAX_RISING) begin
                ev.recorded   = 1'b1;
                ev.pos_number = rising_cnt[PNUM_W-1:0];
                rising_cnt++;
            end
            crossing_cnt++;
            armed = SIDE_MID;
        end
        last_sample = b;
        window_idx++;
        return up || down;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: holds an item until taken, then offers the next one or idles.
    always @(negedge i_clk) begin
        if (!i_s_axis_tvalid || in_taken) begin
            if (!i_rst_n || sample_queue.size() == 0 || $urandom_range(99) < idle_pct) begin
                i_s_axis_tvalid <= 1'b0;
            end else begin
                i_s_axis_tdata  <= sample_queue[0].smp;
                i_s_axis_tuser  <= sample_queue[0].start;
                i_s_axis_tvalid <= 1'b1;
                void'(sample_queue.pop_front());
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        in_taken  = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        out_taken = i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        cfg_taken = i_rst_n && i_cfg_valid && o_cfg_ready;
        if (out_taken) begin
            got_ev.index      = o_m_axis_tdata[11:0];
            got_ev.frac       = o_m_axis_tdata[28:12];
            got_ev.number     = o_m_axis_tdata[35:29];
            got_ev.pos_number = o_m_axis_tdata[41:36];
            got_ev.rising     = o_m_axis_tuser[0];
            got_ev.recorded   = o_m_axis_tuser[1];
            if (pending_crossings.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected crossing item: idx=%0d frac=%0d rising=%0b",
                             got_ev.index, got_ev.frac, got_ev.rising);
                mismatches++;
            end else begin
                want_ev = pending_crossings.pop_front();
                if (got_ev !== want_ev) begin
                    if (mismatches < 10) begin
                        $display("crossing mismatch at %0t", $realtime);
                        $display("  expected idx=%0d frac=%0d rising=%0b num=%0d rec=%0b pnum=%0d",
                                 want_ev.index, want_ev.frac, want_ev.rising, want_ev.number,
                                 want_ev.recorded, want_ev.pos_number);
                        $display("  actual   idx=%0d frac=%0d rising=%0b num=%0d rec=%0b pnum=%0d",
                                 got_ev.index, got_ev.frac, got_ev.rising, got_ev.number,
                                 got_ev.recorded, got_ev.pos_number);
                    end
                    mismatches++;
                end
            end
        end
        if (cfg_taken) hyst_level = i_cfg_data;
        if (in_taken) begin
            if (detect_crossing($signed(i_s_axis_tdata), i_s_axis_tuser, new_ev))
                pending_crossings.push_back(new_ev);
        end
        if (in_taken || out_taken || cfg_taken) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_sample(input int value, input bit start);
        sample_queue.push_back('{smp: value[SAMPLE_W-1:0], start: start});
    endtask

    // Magnitude that stays inside the hysteresis band.
    function automatic int band_mag(input int hy);
        if (hy < 2) return 0;
        return int'($urandom_range(hy - 1, 1));
    endfunction

    // Magnitude that arms a side.
    function automatic int arm_mag(input int hy);
        int hi;
        if ($urandom_range(7) == 0) return SAMPLE_MAX;
        hi = hy * 4 + 16;
        if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
        return int'($urandom_range(hi, hy));
    endfunction

    function automatic int with_sign(input int mag, input bit negative);
        if (!negative) return mag;
        if (mag == SAMPLE_MAX && $urandom_range(1) == 1) return -SAMPLE_MAX - 1;
        return -mag;
    endfunction

    // Windows of half cycles with random content, plus some raw noise.
    task automatic gen_windows(input int n, input int hy);
        int made, len, k, half, mag;
        bit neg;
        made = 0;
        while (made < n) begin
            if ($urandom_range(99) < 85) begin
                neg = $urandom_range(1);
                queue_sample(with_sign(arm_mag(hy), neg), 1'b1);
                len  = $urandom_range(60, 4);
                half = 0;
                for (k = 0; k < len; k++) begin
                    if (half == 0) begin
                        neg  = !neg;
                        half = $urandom_range(6, 1);
                        mag  = $urandom_range(1) ? band_mag(hy) : arm_mag(hy);
                    end else begin
                        mag = ($urandom_range(3) == 0) ? band_mag(hy) : arm_mag(hy);
                    end
                    half--;
                    queue_sample(with_sign(mag, neg), 1'b0);
                end
                made += len + 1;
            end else begin
                queue_sample(int'($urandom_range(24'hFFFFFF)), $urandom_range(7) == 0);
                made++;
            end
        end
    endtask

    // Enough crossings to overflow the rising list and then the crossing limit.
    task automatic gen_crossing_limit(input int hy);
        int k;
        queue_sample(arm_mag(hy), 1'b1);
        for (k = 0; k < 80; k++) begin
            queue_sample(with_sign(arm_mag(hy), 1'b1), 1'b0);
            queue_sample(band_mag(hy), 1'b0);
        end
        for (k = 0; k < 30; k++) begin
            queue_sample(arm_mag(hy), 1'b0);
            queue_sample(-band_mag(hy), 1'b0);
            queue_sample(with_sign(arm_mag(hy), 1'b1), 1'b0);
            queue_sample(band_mag(hy), 1'b0);
        end
    endtask

    // One long window of mostly in-band noise with sparse crossings.
    task automatic gen_long_window(input int hy);
        int k, r;
        queue_sample(0, 1'b1);
        for (k = 0; k < LONG_RUN_LEN; k++) begin
            r = $urandom_range(49);
            if (r == 0) queue_sample(arm_mag(hy), 1'b0);
            else if (r == 1) queue_sample(-arm_mag(hy), 1'b0);
            else queue_sample(int'($urandom_range(2 * (hy - 1))) - (hy - 1), 1'b0);
        end
    endtask

    task automatic settle();
        while (sample_queue.size() != 0 || i_s_axis_tvalid || pending_crossings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_hysteresis(input int unsigned value);
        @(negedge i_clk);
        i_cfg_data  <= value[HYST_W-1:0];
        i_cfg_valid <= 1'b1;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int p, hy;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_m_axis_tready = 1'b0;
        hyst_level      = HYST_RESET;
        last_sample     = 0;
        armed           = SIDE_MID;
        window_idx      = 0;
        crossing_cnt    = 0;
        rising_cnt      = 0;
        in_taken        = 1'b0;
        out_taken       = 1'b0;
        cfg_taken       = 1'b0;
        idle_pct        = 14;
        hold_req        = 1'b0;
        hold_left       = 0;
        quiet_cycles    = 0;
        mismatches      = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset threshold, starting without any window opened.
        queue_sample(0, 1'b0);
        queue_sample(5000, 1'b0);
        queue_sample(-500, 1'b0);
        queue_sample(-SAMPLE_MAX - 1, 1'b0);
        queue_sample(1, 1'b0);
        queue_sample(SAMPLE_MAX, 1'b0);
        queue_sample(-1310, 1'b0);
        queue_sample(100, 1'b0);
        queue_sample(-100, 1'b0);
        queue_sample(SAMPLE_MAX, 1'b1);
        queue_sample(0, 1'b0);
        queue_sample(-1, 1'b0);
        // The side is re-armed before the crossing test.
        queue_sample(-1311, 1'b1);
        queue_sample(1311, 1'b0);
        queue_sample(-1311, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(1, 1'b0);
        queue_sample(1310, 1'b1);
        queue_sample(-1310, 1'b0);
        settle();

        // With no hysteresis, zero arms the positive side.
        write_hysteresis(0);
        queue_sample(0, 1'b1);
        queue_sample(-1, 1'b0);
        queue_sample(5, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(-SAMPLE_MAX - 1, 1'b0);
        settle();

        write_hysteresis(SAMPLE_MAX);
        queue_sample(SAMPLE_MAX, 1'b1);
        queue_sample(-5, 1'b0);
        queue_sample(-SAMPLE_MAX, 1'b0);
        queue_sample(7, 1'b0);
        queue_sample(-SAMPLE_MAX - 1, 1'b0);
        queue_sample(SAMPLE_MAX - 1, 1'b0);
        settle();

        // Long receiver hold-off while the sender keeps offering.
        write_hysteresis(HYST_RESET);
        hold_req = 1'b1;
        gen_crossing_limit(HYST_RESET);
        gen_windows(200, HYST_RESET);
        settle();

        idle_pct = 0;
        gen_long_window(HYST_RESET);
        settle();
        idle_pct = 14;

        for (p = 0; p < 6; p++) begin
            case (p)
                0: hy = $urandom_range(100, 2);
                1: hy = $urandom_range(SAMPLE_MAX);
                2: hy = 0;
                3: hy = SAMPLE_MAX;
                4: hy = $urandom_range(65535, 1000);
                default: hy = 2;
            endcase
            write_hysteresis(hy);
            gen_windows(120, hy);
            settle();
        end

        mismatches += pending_crossings.size();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* hysteresis_zero_cross_detector_top.f */
sv/hzcd_pkg.sv
sv/hzcd_ctrl.sv
sv/hzcd_datapath.sv
sv/hysteresis_zero_cross_detector_top.sv
sv/hzcd_checker.sv
test/testbench.sv
